>>> rtl/qpdc_pkg.sv
// Shared types and constants for the quadratic partition hull core.
`timescale 1ns / 1ps
package qpdc_pkg;

   localparam int MAX_ITEMS = 65535;
   localparam int HULL_AW   = 16;
   localparam int SUM_W     = 24;
   localparam int CNT_W     = 16;
   localparam int CSR_AW    = 2;
   localparam int CSR_DW    = 32;

   localparam logic [CSR_AW-1:0] CSR_COEFF_A = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_COEFF_B = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_COEFF_C = 2'd2;

   typedef struct packed {
      logic [7:0] item_value;
      logic       last_item;
   } req_payload_type;

   typedef struct packed {
      logic signed [63:0] best_total;
      logic               last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic        start;
      logic [63:0] op_a;
      logic [63:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] prod;
   } mul_rsp_type;

endpackage

>>> rtl/qpdc_mul.sv
// Iterative signed 64x64 multiplier built from one 32x32 partial product per cycle.
`timescale 1ns / 1ps
module qpdc_mul import qpdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic [63:0]  mag_a_ff, mag_a_in;
   logic [63:0]  mag_b_ff, mag_b_in;
   logic         neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   step_ff, step_in;
   logic         run_ff, run_in;
   logic         done_ff, done_in;
   logic [31:0]  part_a, part_b;
   logic [63:0]  pp;
   logic [127:0] pp_shift;

   always_comb begin
      unique case (step_ff)
         3'd0:    begin part_a = mag_a_ff[31:0];  part_b = mag_b_ff[31:0];  end
         3'd1:    begin part_a = mag_a_ff[31:0];  part_b = mag_b_ff[63:32]; end
         3'd2:    begin part_a = mag_a_ff[63:32]; part_b = mag_b_ff[31:0];  end
         default: begin part_a = mag_a_ff[63:32]; part_b = mag_b_ff[63:32]; end
      endcase
      pp = part_a * part_b;
      unique case (step_ff)
         3'd0:       pp_shift = {64'd0, pp};
         3'd1, 3'd2: pp_shift = {32'd0, pp, 32'd0};
         default:    pp_shift = {pp, 64'd0};
      endcase
   end

   always_comb begin
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         // take magnitudes; sign goes back on at the end
         mag_a_in = mul_req.op_a[63] ? 64'd0 - mul_req.op_a : mul_req.op_a;
         mag_b_in = mul_req.op_b[63] ? 64'd0 - mul_req.op_b : mul_req.op_b;
         neg_in   = mul_req.op_a[63] ^ mul_req.op_b[63];
         acc_in   = 128'd0;
         step_in  = 3'd0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         if (step_ff < 3'd4) begin
            acc_in  = acc_ff + pp_shift;
            step_in = step_ff + 3'd1;
         end else begin
            acc_in  = neg_ff ? 128'd0 - acc_ff : acc_ff;
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = acc_ff;

endmodule

>>> rtl/quadratic_partition_dp_cht_core.sv
// Top level of the quadratic partition core: sequencer, hull memory and result register.
`timescale 1ns / 1ps
// Splits a stream of non-negative item values into consecutive segments that maximize
// the sum of a*S*S + b*S + c over segments, using a monotone convex hull deque of split
// points kept in a 65536-entry memory with two registered read ports. Each accepted item
// returns one result: the best total of the prefix so far, flagged last when the item
// was marked last or when it is item MAX_ITEMS of its sequence; the hull then restarts.
// All wide arithmetic runs through one shared iterative 64x64 multiplier; one point
// evaluation issues three multiplies in turn. An item spends longer in the core for each
// front test and each back test that it runs, and its push waits while the result
// register is stalled. The input is stalled while an item is at work; a finished result
// waits in the output register and the next item may be taken meanwhile. Memory entry
// zero reads as zero, so no clearing pass is needed after reset or at the end of a
// sequence.
module quadratic_partition_dp_cht_core import qpdc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_payload_type     req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_data,
   input  logic                csr_wr_en,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   typedef enum logic [19:0] {
      ST_IDLE      = 20'd1 << 0,
      ST_F_TEST    = 20'd1 << 1,
      ST_F_LOAD    = 20'd1 << 2,
      ST_F_EV0     = 20'd1 << 3,
      ST_F_EV1     = 20'd1 << 4,
      ST_F_MUL     = 20'd1 << 5,
      ST_BEST_READ = 20'd1 << 6,
      ST_BEST_LOAD = 20'd1 << 7,
      ST_BEST_FIN  = 20'd1 << 8,
      ST_NEW_FIN   = 20'd1 << 9,
      ST_B_TEST    = 20'd1 << 10,
      ST_B_LOAD    = 20'd1 << 11,
      ST_B_EV1     = 20'd1 << 12,
      ST_B_EV0     = 20'd1 << 13,
      ST_B_MUL1    = 20'd1 << 14,
      ST_B_MUL2    = 20'd1 << 15,
      ST_PUSH      = 20'd1 << 16,
      ST_EV1       = 20'd1 << 17,
      ST_EV2       = 20'd1 << 18,
      ST_EV3       = 20'd1 << 19
   } state_type;

   localparam logic [HULL_AW-1:0] TOP_INDEX = HULL_AW'(MAX_ITEMS);

   state_type state_ff, state_in, ret_ff, ret_in;

   // coefficients
   logic signed [7:0]  coeff_a_ff;
   logic signed [31:0] coeff_b_ff, coeff_c_ff;
   logic [63:0]        coef_a64, coef_b64, coef_c64;

   // sequence state
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [HULL_AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic               last_ff, last_in;

   // point registers and evaluation scratch
   logic [SUM_W-1:0]   p0_s_ff, p0_s_in, p1_s_ff, p1_s_in;
   logic [63:0]        p0_b_ff, p0_b_in, p1_b_ff, p1_b_in;
   logic [63:0]        ev_s_ff, ev_s_in, ev_b_ff, ev_b_in;
   logic [63:0]        ev_t1_ff, ev_t1_in, ev_t2_ff, ev_t2_in, ev_t3_ff, ev_t3_in;
   logic [63:0]        ev_ord_ff, ev_ord_in, ev_abs_ff, ev_abs_in;
   logic [63:0]        pa_ord_ff, pa_ord_in, pa_abs_ff, pa_abs_in;
   logic [63:0]        ynew_ff, ynew_in, xnew_ff, xnew_in;
   logic [63:0]        best_ff, best_in;
   logic [63:0]        d0_ff, d0_in, d1_ff, d1_in, d2_ff, d2_in, d3_ff, d3_in;
   logic [127:0]       lhs_ff, lhs_in;
   logic               issued_ff, issued_in;

   // hull memory
   logic [SUM_W-1:0]   sum_mem  [2**HULL_AW];
   logic [63:0]        best_mem [2**HULL_AW];
   logic [HULL_AW-1:0] rd_addr0, rd_addr1, wr_addr;
   logic               wr_en;
   logic [SUM_W-1:0]   rd_s0_ff, rd_s1_ff, rd_s0, rd_s1;
   logic [63:0]        rd_b0_ff, rd_b1_ff, rd_b0, rd_b1;
   logic               rd_zero0_ff, rd_zero1_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   mul_req_type        mul_req;
   mul_rsp_type        mul_rsp;
   logic               mul_state;

   logic               req_take;
   logic               out_free;
   logic               front_go, back_go;
   logic               seq_end;

   qpdc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign coef_a64 = {{56{coeff_a_ff[7]}}, coeff_a_ff};
   assign coef_b64 = {{32{coeff_b_ff[31]}}, coeff_b_ff};
   assign coef_c64 = {{32{coeff_c_ff[31]}}, coeff_c_ff};

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign front_go  = (head_ff < tail_ff) && (head_ff != TOP_INDEX);
   assign back_go   = (head_ff < tail_ff);
   assign seq_end   = last_ff || (count_ff == CNT_W'(MAX_ITEMS));

   // configuration writes; an index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_a_ff <= -8'sd1;
         coeff_b_ff <= 32'sd0;
         coeff_c_ff <= 32'sd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEFF_A: coeff_a_ff <= csr_wdata[7:0];
            CSR_COEFF_B: coeff_b_ff <= csr_wdata;
            CSR_COEFF_C: coeff_c_ff <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // read port 0 carries the lower deque point, port 1 the upper one
   always_comb begin
      if (state_ff == ST_B_TEST) begin
         rd_addr0 = tail_ff - HULL_AW'(1);
         rd_addr1 = tail_ff;
      end else begin
         rd_addr0 = head_ff;
         rd_addr1 = head_ff + HULL_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sum_mem[wr_addr]  <= sum_ff;
         best_mem[wr_addr] <= best_ff;
      end
      rd_s0_ff    <= sum_mem[rd_addr0];
      rd_b0_ff    <= best_mem[rd_addr0];
      rd_s1_ff    <= sum_mem[rd_addr1];
      rd_b1_ff    <= best_mem[rd_addr1];
      rd_zero0_ff <= (rd_addr0 == '0);
      rd_zero1_ff <= (rd_addr1 == '0);
   end

   // entry zero is the origin point (0, 0) and is never written
   assign rd_s0 = rd_zero0_ff ? '0 : rd_s0_ff;
   assign rd_b0 = rd_zero0_ff ? '0 : rd_b0_ff;
   assign rd_s1 = rd_zero1_ff ? '0 : rd_s1_ff;
   assign rd_b1 = rd_zero1_ff ? '0 : rd_b1_ff;

   // shared multiplier operands
   always_comb begin
      mul_state = 1'b1;
      unique case (state_ff)
         ST_EV1:    begin mul_req.op_a = coef_a64; mul_req.op_b = ev_s_ff; end
         ST_EV2:    begin mul_req.op_a = ev_t1_ff; mul_req.op_b = ev_s_ff; end
         ST_EV3:    begin mul_req.op_a = coef_b64; mul_req.op_b = ev_s_ff; end
         ST_F_MUL:  begin mul_req.op_a = {40'd0, sum_ff}; mul_req.op_b = d1_ff; end
         ST_B_MUL1: begin mul_req.op_a = d0_ff; mul_req.op_b = d1_ff; end
         ST_B_MUL2: begin mul_req.op_a = d2_ff; mul_req.op_b = d3_ff; end
         default: begin
            mul_req.op_a = d0_ff;
            mul_req.op_b = d1_ff;
            mul_state    = 1'b0;
         end
      endcase
      mul_req.start = mul_state && !issued_ff;
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      p0_s_in      = p0_s_ff;
      p0_b_in      = p0_b_ff;
      p1_s_in      = p1_s_ff;
      p1_b_in      = p1_b_ff;
      ev_s_in      = ev_s_ff;
      ev_b_in      = ev_b_ff;
      ev_t1_in     = ev_t1_ff;
      ev_t2_in     = ev_t2_ff;
      ev_t3_in     = ev_t3_ff;
      ev_ord_in    = ev_ord_ff;
      ev_abs_in    = ev_abs_ff;
      pa_ord_in    = pa_ord_ff;
      pa_abs_in    = pa_abs_ff;
      ynew_in      = ynew_ff;
      xnew_in      = xnew_ff;
      best_in      = best_ff;
      d0_in        = d0_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      d3_in        = d3_ff;
      lhs_in       = lhs_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff + HULL_AW'(1);
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // track the single outstanding multiply
      issued_in = issued_ff;
      if (mul_req.start) issued_in = 1'b1;
      if (mul_rsp.done)  issued_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sum_in   = sum_ff + SUM_W'(req_data.item_value);
               count_in = count_ff + CNT_W'(1);
               last_in  = req_data.last_item;
               state_in = ST_F_TEST;
            end
         end
         // front: pop while the next point is at least as good
         ST_F_TEST: state_in = front_go ? ST_F_LOAD : ST_BEST_READ;
         ST_F_LOAD: begin
            p0_s_in  = rd_s0;
            p0_b_in  = rd_b0;
            p1_s_in  = rd_s1;
            p1_b_in  = rd_b1;
            ev_s_in  = {40'd0, rd_s0};
            ev_b_in  = rd_b0;
            ret_in   = ST_F_EV0;
            state_in = ST_EV1;
         end
         ST_F_EV0: begin
            pa_ord_in = ev_ord_ff;
            pa_abs_in = ev_abs_ff;
            ev_s_in   = {40'd0, p1_s_ff};
            ev_b_in   = p1_b_ff;
            ret_in    = ST_F_EV1;
            state_in  = ST_EV1;
         end
         ST_F_EV1: begin
            d0_in    = ev_ord_ff - pa_ord_ff;
            d1_in    = ev_abs_ff - pa_abs_ff;
            state_in = ST_F_MUL;
         end
         ST_F_MUL: begin
            if (mul_rsp.done) begin
               if ($signed(mul_rsp.prod) <= $signed({{64{d0_ff[63]}}, d0_ff})) begin
                  head_in  = head_ff + HULL_AW'(1);
                  state_in = ST_F_TEST;
               end else begin
                  state_in = ST_BEST_READ;
               end
            end
         end
         ST_BEST_READ: state_in = ST_BEST_LOAD;
         ST_BEST_LOAD: begin
            ev_s_in  = {40'd0, sum_ff} - {40'd0, rd_s0};
            ev_b_in  = rd_b0;
            ret_in   = ST_BEST_FIN;
            state_in = ST_EV1;
         end
         ST_BEST_FIN: begin
            // ev_ord holds bj + a*d*d - b*d; add 2*b*d back and c
            best_in  = ev_ord_ff + {ev_t3_ff[62:0], 1'b0} + coef_c64;
            ev_s_in  = {40'd0, sum_ff};
            ev_b_in  = best_in;
            ret_in   = ST_NEW_FIN;
            state_in = ST_EV1;
         end
         ST_NEW_FIN: begin
            ynew_in  = ev_ord_ff;
            xnew_in  = ev_abs_ff;
            state_in = ST_B_TEST;
         end
         // back: pop while the new point makes the tail redundant
         ST_B_TEST: state_in = back_go ? ST_B_LOAD : ST_PUSH;
         ST_B_LOAD: begin
            p0_s_in  = rd_s0;
            p0_b_in  = rd_b0;
            ev_s_in  = {40'd0, rd_s1};
            ev_b_in  = rd_b1;
            ret_in   = ST_B_EV1;
            state_in = ST_EV1;
         end
         ST_B_EV1: begin
            pa_ord_in = ev_ord_ff;
            pa_abs_in = ev_abs_ff;
            ev_s_in   = {40'd0, p0_s_ff};
            ev_b_in   = p0_b_ff;
            ret_in    = ST_B_EV0;
            state_in  = ST_EV1;
         end
         ST_B_EV0: begin
            d0_in    = pa_abs_ff - ev_abs_ff;
            d1_in    = ynew_ff - pa_ord_ff;
            d2_in    = xnew_ff - pa_abs_ff;
            d3_in    = pa_ord_ff - ev_ord_ff;
            state_in = ST_B_MUL1;
         end
         ST_B_MUL1: begin
            if (mul_rsp.done) begin
               lhs_in   = mul_rsp.prod;
               state_in = ST_B_MUL2;
            end
         end
         ST_B_MUL2: begin
            if (mul_rsp.done) begin
               if ($signed(lhs_ff) <= $signed(mul_rsp.prod)) begin
                  tail_in  = tail_ff - HULL_AW'(1);
                  state_in = ST_B_TEST;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            // hold until the result register is free
            if (out_free) begin
               if (tail_ff != TOP_INDEX) begin
                  wr_en   = 1'b1;
                  tail_in = tail_ff + HULL_AW'(1);
               end
               rsp_valid_in            = 1'b1;
               rsp_data_in.best_total  = best_ff;
               rsp_data_in.last_result = seq_end;
               if (seq_end) begin
                  sum_in   = '0;
                  count_in = '0;
                  head_in  = '0;
                  tail_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         // point evaluation: ord = best + a*s*s - b*s, abs = 2*a*s
         ST_EV1: begin
            if (mul_rsp.done) begin
               ev_t1_in = mul_rsp.prod[63:0];
               state_in = ST_EV2;
            end
         end
         ST_EV2: begin
            if (mul_rsp.done) begin
               ev_t2_in = mul_rsp.prod[63:0];
               state_in = ST_EV3;
            end
         end
         ST_EV3: begin
            if (mul_rsp.done) begin
               ev_t3_in  = mul_rsp.prod[63:0];
               ev_ord_in = ev_b_ff + ev_t2_ff - mul_rsp.prod[63:0];
               ev_abs_in = {ev_t1_ff[62:0], 1'b0};
               state_in  = ret_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         last_ff      <= 1'b0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         last_ff      <= last_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p0_s_ff     <= p0_s_in;
      p0_b_ff     <= p0_b_in;
      p1_s_ff     <= p1_s_in;
      p1_b_ff     <= p1_b_in;
      ev_s_ff     <= ev_s_in;
      ev_b_ff     <= ev_b_in;
      ev_t1_ff    <= ev_t1_in;
      ev_t2_ff    <= ev_t2_in;
      ev_t3_ff    <= ev_t3_in;
      ev_ord_ff   <= ev_ord_in;
      ev_abs_ff   <= ev_abs_in;
      pa_ord_ff   <= pa_ord_in;
      pa_abs_ff   <= pa_abs_in;
      ynew_ff     <= ynew_in;
      xnew_ff     <= xnew_in;
      best_ff     <= best_in;
      d0_ff       <= d0_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      d3_ff       <= d3_in;
      lhs_ff      <= lhs_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/sv/qpdc_checker.sv
// Checker for the quadratic partition core: hull predictor and result comparison.
`timescale 1ns / 1ps
module qpdc_checker import qpdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_payload_type   req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_payload_type   rsp_data,
   input  logic              csr_wr_en,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   output int                fail_count,
   output int                totals_pending
);

   logic [63:0] coef_a, coef_b, coef_c;
   logic [SUM_W-1:0] prefix_sum;
   int unsigned seq_count, hull_front, hull_back;
   logic [SUM_W-1:0] split_sum [0:MAX_ITEMS];
   logic [63:0] split_best [0:MAX_ITEMS];
   rsp_payload_type total_q[$];

   function automatic logic [63:0] hull_y(logic [63:0] s, logic [63:0] b);
      return b + coef_a * s * s - coef_b * s;
   endfunction

   function automatic logic [63:0] hull_x(logic [63:0] s);
      return 64'd2 * coef_a * s;
   endfunction

   function automatic logic signed [127:0] wide_mul(logic [63:0] x, logic [63:0] y);
      logic signed [127:0] xs, ys;
      xs = {{64{x[63]}}, x};
      ys = {{64{y[63]}}, y};
      return xs * ys;
   endfunction

   function automatic rsp_payload_type partition_step(req_payload_type it);
      logic [63:0] s, sj, d, best, up, dn, ynew, xnew, yt, yp, xt, xp;
      logic last;
      rsp_payload_type r;
      last = it.last_item;
      seq_count++;
      prefix_sum = prefix_sum + it.item_value;
      s = {40'd0, prefix_sum};
      // pop the front while the next split point is at least as good
      while (hull_front < hull_back && hull_front + 1 <= MAX_ITEMS) begin
         up = hull_y(split_sum[hull_front+1], split_best[hull_front+1])
            - hull_y(split_sum[hull_front], split_best[hull_front]);
         dn = hull_x(split_sum[hull_front+1]) - hull_x(split_sum[hull_front]);
         if (wide_mul(s, dn) <= wide_mul(up, 64'd1)) hull_front++;
         else break;
      end
      sj = split_sum[hull_front];
      d = s - sj;
      best = split_best[hull_front] + coef_a * d * d + coef_b * d + coef_c;
      ynew = hull_y(s, best);
      xnew = hull_x(s);
      // drop back points that fall under the new upper hull
      while (hull_front < hull_back && hull_back <= MAX_ITEMS) begin
         yt = hull_y(split_sum[hull_back], split_best[hull_back]);
         yp = hull_y(split_sum[hull_back-1], split_best[hull_back-1]);
         xt = hull_x(split_sum[hull_back]);
         xp = hull_x(split_sum[hull_back-1]);
         if (wide_mul(xt - xp, ynew - yt) <= wide_mul(xnew - xt, yt - yp)) hull_back--;
         else break;
      end
      if (hull_back + 1 <= MAX_ITEMS) begin
         hull_back++;
         split_sum[hull_back] = prefix_sum;
         split_best[hull_back] = best;
      end
      if (seq_count >= MAX_ITEMS) last = 1'b1;
      r.best_total = best;
      r.last_result = last;
      if (last) begin
         prefix_sum = '0;
         seq_count = 0;
         hull_front = 0;
         hull_back = 0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         coef_a = {64{1'b1}};
         coef_b = '0;
         coef_c = '0;
         prefix_sum = '0;
         seq_count = 0;
         hull_front = 0;
         hull_back = 0;
         split_sum[0] = '0;
         split_best[0] = '0;
         total_q.delete();
         fail_count <= 0;
         totals_pending <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COEFF_A: coef_a = {{56{csr_wdata[7]}}, csr_wdata[7:0]};
               CSR_COEFF_B: coef_b = {{32{csr_wdata[31]}}, csr_wdata};
               CSR_COEFF_C: coef_c = {{32{csr_wdata[31]}}, csr_wdata};
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (total_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: total %0d last %0b",
                           rsp_data.best_total, rsp_data.last_result);
               fail_count <= fail_count + 1;
            end else begin
               want = total_q.pop_front();
               if (want.best_total !== rsp_data.best_total ||
                   want.last_result !== rsp_data.last_result) begin
                  if (fail_count < 10)
                     $display("result mismatch: expected total %0d last %0b, got %0d last %0b",
                              $signed(want.best_total), want.last_result,
                              $signed(rsp_data.best_total), rsp_data.last_result);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) total_q.push_back(partition_step(req_data));
         totals_pending <= total_q.size();
      end
   end

endmodule

>>> tb/sv/tb_top.sv
// Stimulus top for the quadratic partition core: clock, reset, items, settings, verdict.
`timescale 1ns / 1ps
module tb_top;
   import qpdc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_AW-1:0] csr_index = CSR_COEFF_A;
   logic [CSR_DW-1:0] csr_wdata = '0;
   int fail_count, totals_pending;

   // idle and stall odds, in percent, for the current phase
   int send_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   localparam int WATCHDOG_LIMIT = 60000;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   quadratic_partition_dp_cht_core dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata
   );

   qpdc_checker scoreboard (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata,
      .fail_count, .totals_pending
   );

   // Receiver side: stall at random per the phase odds.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one item and hold it until the block takes it; then idle at random.
   task automatic send_item(logic [7:0] value, logic last);
      int gap;
      req_valid <= 1'b1;
      req_data <= '{item_value: value, last_item: last};
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every result is back, then let the core settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (totals_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_coeffs(logic [7:0] a, logic [31:0] b, logic [31:0] c);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_COEFF_A;
      csr_wdata <= {24'd0, a};
      @(posedge clock);
      csr_index <= CSR_COEFF_B;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= CSR_COEFF_C;
      csr_wdata <= c;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed short sequences with random values; a few zero items.
   task automatic random_items(int count);
      logic [7:0] v;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(29) == 0) v = 8'd0;
         else if ($urandom_range(9) == 0) v = 8'd255;
         else v = 8'($urandom_range(1, 255));
         send_item(v, $urandom_range(11) == 0);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, zero item, end of sequence, at reset coefficients.
      send_item(8'd255, 1'b0);
      send_item(8'd1, 1'b0);
      send_item(8'd0, 1'b0);
      send_item(8'd128, 1'b1);
      send_item(8'd1, 1'b1);
      drain();
      write_coeffs(8'h80, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(8'd255, 1'b0);
      send_item(8'd255, 1'b0);
      send_item(8'd1, 1'b0);
      send_item(8'd170, 1'b0);
      send_item(8'd85, 1'b1);
      drain();
      write_coeffs(8'hFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(8'd85, 1'b0);
      send_item(8'd170, 1'b0);
      send_item(8'd0, 1'b0);
      send_item(8'd255, 1'b1);
      drain();
      // out-of-range coefficient: a zero, then positive
      write_coeffs(8'h00, 32'd100, 32'hFFFF_FF00);
      send_item(8'd10, 1'b0);
      send_item(8'd200, 1'b0);
      send_item(8'd3, 1'b1);
      drain();
      write_coeffs(8'h7F, 32'hFFFF_0000, 32'd5000);
      send_item(8'd7, 1'b0);
      send_item(8'd250, 1'b0);
      send_item(8'd9, 1'b1);
      drain();

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         case (phase)
            0: write_coeffs(8'hFF, 32'd0, 32'd0);
            1: write_coeffs(8'h80, 32'h7FFF_FFFF, 32'h8000_0000);
            2: write_coeffs(8'hF0, $urandom_range(50000), $urandom);
            3: write_coeffs(8'(32'd0 - $urandom_range(1, 128)), $urandom, $urandom);
            4: write_coeffs(8'($urandom), $urandom, $urandom);
            5: write_coeffs(8'hFE, 32'd30000, 32'hFFF0_0000);
            6: write_coeffs(8'(32'h80 + $urandom_range(127)), $urandom, $urandom);
            default: write_coeffs(8'hFF, 32'h8000_0000, 32'h7FFF_FFFF);
         endcase
         random_items(40);
         // hold off the sender until every result is back
         drain();
         random_items(45);
         drain();
      end

      stall_pct = 0;
      drain();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
